FILE: rtl/gps_pkg.sv
// Shared widths, types and constants of the polar Gaussian sampler.
`timescale 1ns / 1ps
package gps_pkg;

	// Field widths
	localparam int U_W         = 16;
	localparam int F_W         = U_W - 1;
	localparam int S_W         = 2 * F_W;
	localparam int SAMPLE_BITS = 24;
	localparam int SF_W        = SAMPLE_BITS - 8;
	localparam int STD_W       = 16;
	localparam int STD_SHIFT   = 28 - SF_W;

	// Logarithm datapath
	localparam int LOGQ  = 30;
	localparam int T_W   = LOGQ + 1;
	localparam int K_W   = $clog2(S_W + 1);
	localparam int P_W   = $clog2(S_W);
	localparam int L_W   = K_W + LOGQ;
	localparam int LN_W  = 23;
	localparam logic [LN_W-1:0] TWO_LN2 = 23'd5814540;
	localparam int NUM_W = L_W + LN_W - 22;

	// Divider and square root
	localparam int NADJ_W = NUM_W + 1;
	localparam int DVD_W  = NADJ_W + 26;
	localparam int DVS_W  = T_W - 6;
	localparam int Q_W    = DVD_W - DVS_W + 1;
	localparam int R_W    = (Q_W + 1) / 2;
	localparam int SQ_W   = 2 * R_W;
	localparam int SR_W   = R_W + 2;
	localparam int H_W    = K_W - 1;

	// Scaling
	localparam int W_W   = F_W + R_W;
	localparam int PR_W  = STD_W + W_W;
	localparam int M_W   = PR_W - STD_SHIFT;
	localparam int TOT_W = M_W + 2;
	localparam logic signed [TOT_W-1:0] SAMPLE_MAX =
		TOT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [TOT_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - TOT_W'(1);

	// Configuration register indexes
	localparam int CFG_A_W = 1;
	localparam logic [CFG_A_W-1:0] REG_MEAN = 1'b0;
	localparam logic [CFG_A_W-1:0] REG_STD  = 1'b1;
	localparam logic [STD_W-1:0]   STD_RESET = 16'd4096;

	typedef struct packed {
		logic [F_W-1:0] mag_u;
		logic [F_W-1:0] mag_v;
		logic           neg_u;
		logic           neg_v;
	} pair_t;

	typedef struct packed {
		logic [LOGQ-1:0]  frac;
		logic [K_W-1:0]   k;
		logic [DVS_W-1:0] dvs;
		pair_t            pair;
	} log_out_t;

	typedef struct packed {
		logic [R_W-1:0] root;
		logic [H_W-1:0] h;
		pair_t          pair;
	} root_out_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] a;
		logic [SAMPLE_BITS-1:0] b;
	} samples_t;

	typedef enum logic [1:0] {
		OUT_EMPTY,
		OUT_FIRST,
		OUT_SECOND
	} out_state_t;

endpackage

FILE: rtl/gps_front.sv
// Radius test, normalization and squaring log2 pipeline.
`timescale 1ns / 1ps
module gps_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    in_acc,
	input  logic [gps_pkg::U_W-1:0] u_in,
	input  logic [gps_pkg::U_W-1:0] v_in,
	output logic                    out_valid,
	output gps_pkg::log_out_t       out_data
);
	import gps_pkg::*;

	logic [U_W-1:0]   um, vm;
	logic [2*U_W-1:0] uu, vv;
	logic [2*U_W:0]   s_full;
	logic             s_ok;

	logic             v_s1;
	logic [S_W-1:0]   s_s1;
	pair_t            pair_s1;

	logic [P_W-1:0]   msb;
	logic [P_W:0]     sh_norm;
	logic [T_W-1:0]   t_norm;
	logic [K_W-1:0]   k_norm;

	logic             lg_v_s [LOGQ+1];
	logic [T_W-1:0]   lg_x_s [LOGQ+1];
	logic [LOGQ-1:0]  lg_f_s [LOGQ+1];
	logic [K_W-1:0]   lg_k_s [LOGQ+1];
	logic [DVS_W-1:0] lg_d_s [LOGQ+1];
	pair_t            lg_p_s [LOGQ+1];

	// Magnitudes and squared radius; reject the origin and points on or outside the circle.
	always_comb begin
		um = u_in[U_W-1] ? (~u_in + U_W'(1)) : u_in;
		vm = v_in[U_W-1] ? (~v_in + U_W'(1)) : v_in;
		uu = um * um;
		vv = vm * vm;
		s_full = {1'b0, uu} + {1'b0, vv};
		s_ok = (s_full != '0) && (s_full[2*U_W:S_W] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_acc && s_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s1 <= s_full[S_W-1:0];
			pair_s1 <= '{mag_u: um[F_W-1:0], mag_v: vm[F_W-1:0],
				neg_u: u_in[U_W-1], neg_v: v_in[U_W-1]};
		end
	end

	// Normalize s into [1,2) and keep the exponent.
	always_comb begin
		msb = '0;
		for (int i = 0; i < S_W; i++) begin
			if (s_s1[i]) begin
				msb = P_W'(i);
			end
		end
		sh_norm = (P_W+1)'(LOGQ) - {1'b0, msb};
		t_norm = T_W'(s_s1) << sh_norm;
		k_norm = K_W'(S_W) - K_W'(msb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_v_s[0] <= 1'b0;
		end else if (adv) begin
			lg_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lg_x_s[0] <= t_norm;
			lg_f_s[0] <= '0;
			lg_k_s[0] <= k_norm;
			lg_d_s[0] <= t_norm[T_W-1:6];
			lg_p_s[0] <= pair_s1;
		end
	end

	// One squaring per stage yields one fraction bit of log2(t).
	for (genvar j = 0; j < LOGQ; j++) begin : g_log
		logic [2*T_W-1:0] prod;
		logic [T_W:0]     y;
		logic [T_W-1:0]   xn;
		logic [LOGQ-1:0]  fn;

		always_comb begin
			prod = lg_x_s[j] * lg_x_s[j];
			y = prod[2*T_W-1:LOGQ];
			if (y[T_W]) begin
				xn = y[T_W:1];
				fn = lg_f_s[j] | (LOGQ'(1) << (LOGQ - 1 - j));
			end else begin
				xn = y[T_W-1:0];
				fn = lg_f_s[j];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				lg_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				lg_v_s[j+1] <= lg_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lg_x_s[j+1] <= xn;
				lg_f_s[j+1] <= fn;
				lg_k_s[j+1] <= lg_k_s[j];
				lg_d_s[j+1] <= lg_d_s[j];
				lg_p_s[j+1] <= lg_p_s[j];
			end
		end
	end

	assign out_valid = lg_v_s[LOGQ];
	assign out_data = '{frac: lg_f_s[LOGQ], k: lg_k_s[LOGQ], dvs: lg_d_s[LOGQ],
		pair: lg_p_s[LOGQ]};

endmodule

FILE: rtl/gps_divsqrt.sv
// Scaling by 2 ln 2, pipelined restoring divider and square-root pipeline.
`timescale 1ns / 1ps
module gps_divsqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  gps_pkg::log_out_t  in_data,
	output logic               out_valid,
	output gps_pkg::root_out_t out_data
);
	import gps_pkg::*;

	logic [L_W-1:0]      lval;
	logic [L_W+LN_W-1:0] lprod;

	logic                v_s1;
	logic [NUM_W-1:0]    num_s1;
	logic [K_W-1:0]      k_s1;
	logic [DVS_W-1:0]    dvs_s1;
	pair_t               pair_s1;

	logic [NADJ_W-1:0]   num_adj;
	logic [DVD_W-1:0]    dvd;

	logic                dv_v_s [Q_W+1];
	logic [DVS_W-1:0]    dv_r_s [Q_W+1];
	logic [Q_W-1:0]      dv_q_s [Q_W+1];
	logic [DVS_W-1:0]    dv_d_s [Q_W+1];
	logic [H_W-1:0]      dv_h_s [Q_W+1];
	pair_t               dv_p_s [Q_W+1];

	logic                sq_v_s [R_W+1];
	logic [SR_W-1:0]     sq_r_s [R_W+1];
	logic [R_W-1:0]      sq_t_s [R_W+1];
	logic [SQ_W-1:0]     sq_x_s [R_W+1];
	logic [H_W-1:0]      sq_h_s [R_W+1];
	pair_t               sq_p_s [R_W+1];

	// L = k - log2(t), times 2 ln 2.
	always_comb begin
		lval = {in_data.k, {LOGQ{1'b0}}} - L_W'(in_data.frac);
		lprod = lval * TWO_LN2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1 <= lprod[L_W+LN_W-1:22];
			k_s1 <= in_data.k;
			dvs_s1 <= in_data.dvs;
			pair_s1 <= in_data.pair;
		end
	end

	// An odd exponent folds one factor of two into the numerator.
	always_comb begin
		num_adj = k_s1[0] ? {num_s1, 1'b0} : {1'b0, num_s1};
		dvd = {num_adj, 26'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_r_s[0] <= DVS_W'(dvd[DVD_W-1:Q_W]);
			dv_q_s[0] <= dvd[Q_W-1:0];
			dv_d_s[0] <= dvs_s1;
			dv_h_s[0] <= k_s1[K_W-1:1];
			dv_p_s[0] <= pair_s1;
		end
	end

	// One quotient bit per stage; dividend bits leave the top as quotient bits enter.
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		logic [DVS_W:0]   rem2;
		logic             ge;
		logic [DVS_W-1:0] rem_n;

		always_comb begin
			rem2 = {dv_r_s[j], dv_q_s[j][Q_W-1]};
			ge = rem2 >= {1'b0, dv_d_s[j]};
			rem_n = ge ? DVS_W'(rem2 - {1'b0, dv_d_s[j]}) : rem2[DVS_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_r_s[j+1] <= rem_n;
				dv_q_s[j+1] <= {dv_q_s[j][Q_W-2:0], ge};
				dv_d_s[j+1] <= dv_d_s[j];
				dv_h_s[j+1] <= dv_h_s[j];
				dv_p_s[j+1] <= dv_p_s[j];
			end
		end
	end

	// Square-root entry.
	always_comb begin
		sq_v_s[0] = dv_v_s[Q_W];
		sq_r_s[0] = '0;
		sq_t_s[0] = '0;
		sq_x_s[0] = SQ_W'(dv_q_s[Q_W]);
		sq_h_s[0] = dv_h_s[Q_W];
		sq_p_s[0] = dv_p_s[Q_W];
	end

	// One root bit per stage, two radicand bits consumed each time.
	for (genvar j = 0; j < R_W; j++) begin : g_sqrt
		logic [SR_W+1:0] rem4;
		logic [SR_W-1:0] trial;
		logic            ge;
		logic [SR_W-1:0] rem_n;

		always_comb begin
			rem4 = {sq_r_s[j], sq_x_s[j][SQ_W-1:SQ_W-2]};
			trial = {sq_t_s[j], 2'b01};
			ge = rem4 >= (SR_W+2)'(trial);
			rem_n = ge ? SR_W'(rem4 - (SR_W+2)'(trial)) : rem4[SR_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[j+1] <= sq_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_r_s[j+1] <= rem_n;
				sq_t_s[j+1] <= {sq_t_s[j][R_W-2:0], ge};
				sq_x_s[j+1] <= {sq_x_s[j][SQ_W-3:0], 2'b00};
				sq_h_s[j+1] <= sq_h_s[j];
				sq_p_s[j+1] <= sq_p_s[j];
			end
		end
	end

	assign out_valid = sq_v_s[R_W];
	assign out_data = '{root: sq_t_s[R_W], h: sq_h_s[R_W], pair: sq_p_s[R_W]};

endmodule

FILE: rtl/gps_scale.sv
// Multiplies both uniforms by the radius factor and the deviation, adds the mean.
`timescale 1ns / 1ps
module gps_scale (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_valid,
	input  gps_pkg::root_out_t              in_data,
	input  logic [gps_pkg::STD_W-1:0]       std_dev,
	input  logic [gps_pkg::SAMPLE_BITS-1:0] mean_value,
	output logic                            out_valid,
	output gps_pkg::samples_t               out_data
);
	import gps_pkg::*;

	logic             v_s1;
	logic [W_W-1:0]   wu_s1, wv_s1;
	logic [H_W-1:0]   h_s1;
	logic             nu_s1, nv_s1;

	logic [H_W-1:0]   sh;
	logic [W_W-1:0]   zu, zv;

	logic             v_s2;
	logic [PR_W-1:0]  pu_s2, pv_s2;
	logic             nu_s2, nv_s2;

	// Apply the sign, add the mean and clamp to the sample range.
	function automatic logic [SAMPLE_BITS-1:0] finish(input logic neg,
		input logic [PR_W-1:0] p, input logic [SAMPLE_BITS-1:0] mean);
		logic signed [TOT_W-1:0] m;
		logic signed [TOT_W-1:0] tot;
		m = signed'(TOT_W'(p[PR_W-1:STD_SHIFT]));
		tot = signed'({{(TOT_W-SAMPLE_BITS){mean[SAMPLE_BITS-1]}}, mean});
		tot = neg ? (tot - m) : (tot + m);
		if (tot > SAMPLE_MAX) begin
			tot = SAMPLE_MAX;
		end else if (tot < SAMPLE_MIN) begin
			tot = SAMPLE_MIN;
		end
		return tot[SAMPLE_BITS-1:0];
	endfunction

	// Stage 1: magnitude times root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wu_s1 <= W_W'(in_data.pair.mag_u) * W_W'(in_data.root);
			wv_s1 <= W_W'(in_data.pair.mag_v) * W_W'(in_data.root);
			h_s1 <= in_data.h;
			nu_s1 <= in_data.pair.neg_u;
			nv_s1 <= in_data.pair.neg_v;
		end
	end

	// Stage 2: exponent shift, then deviation product.
	always_comb begin
		sh = H_W'(F_W) - h_s1;
		zu = wu_s1 >> sh;
		zv = wv_s1 >> sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s2 <= PR_W'(std_dev) * PR_W'(zu);
			pv_s2 <= PR_W'(std_dev) * PR_W'(zv);
			nu_s2 <= nu_s1;
			nv_s2 <= nv_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data = '{a: finish(nu_s2, pu_s2, mean_value),
		b: finish(nv_s2, pv_s2, mean_value)};

endmodule

FILE: rtl/gps_out.sv
// Output register that sends a finished pair as two beats.
`timescale 1ns / 1ps
module gps_out (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pair_valid,
	input  gps_pkg::samples_t               pair_in,
	output logic                            take,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gps_pkg::SAMPLE_BITS-1:0] m_sample,
	output logic                            m_tlast
);
	import gps_pkg::*;

	out_state_t state_q, state_d;
	samples_t   pair_q;
	logic       load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OUT_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pair_q <= pair_in;
		end
	end

	// A new pair loads when empty or while the second beat leaves.
	always_comb begin
		state_d = state_q;
		take = 1'b0;
		m_tvalid = 1'b0;
		m_tlast = 1'b0;
		m_sample = pair_q.a;
		case (state_q)
			OUT_EMPTY: begin
				take = 1'b1;
				if (pair_valid) begin
					state_d = OUT_FIRST;
				end
			end
			OUT_FIRST: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = OUT_SECOND;
				end
			end
			OUT_SECOND: begin
				m_tvalid = 1'b1;
				m_tlast = 1'b1;
				m_sample = pair_q.b;
				take = m_tready;
				if (m_tready) begin
					state_d = pair_valid ? OUT_FIRST : OUT_EMPTY;
				end
			end
			default: begin
				state_d = OUT_EMPTY;
			end
		endcase
		load = take && pair_valid;
	end

endmodule

FILE: rtl/gaussian_polar_sampler.sv
// Top level of the polar-method Gaussian sampler.
// Usage:
// The slave stream takes one pair of signed Q1.15 uniforms per beat (u low, v high).
// A pair with s = u*u + v*v equal to zero or at least one is dropped silently.
// A kept pair yields two master beats: mean + std*u*f, then mean + std*v*f with
// tlast set; samples are Q8.16 and clamp at the range limits.
// The second beat follows the first once the receiver is ready. The path is a
// 30-stage squaring log2, a 39-stage restoring divider and a 20-stage square root.
// Accepted pairs are never taken back to back, matching one sample per cycle
// while the receiver is ready.
// The configuration port writes mean_value (index 0) and std_dev (index 1); write
// only while no item is in flight.
// Reset clears all valid bits and loads mean 0 and std_dev 4096 (1.0).
// When the receiver stalls with a pair pending, the whole pipeline holds and
// tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module gaussian_polar_sampler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gps_pkg::CFG_A_W-1:0]         cfg_addr,
	input  logic [gps_pkg::SAMPLE_BITS-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [2*gps_pkg::U_W-1:0]           s_tdata,  // uniform_u, uniform_v
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gps_pkg::SAMPLE_BITS-1:0]     m_tdata,  // sample
	output logic                                m_tlast   // last
);
	import gps_pkg::*;

	logic [SAMPLE_BITS-1:0] mean_q;
	logic [STD_W-1:0]       std_q;
	logic                   took_q;
	logic                   adv;
	logic                   in_acc;
	logic                   take;

	logic                   lg_valid;
	log_out_t               lg_data;
	logic                   rt_valid;
	root_out_t              rt_data;
	logic                   sc_valid;
	samples_t               sc_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			std_q <= STD_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MEAN: mean_q <= cfg_data;
				REG_STD:  std_q <= cfg_data[STD_W-1:0];
				default:  ;
			endcase
		end
	end

	// The pipeline moves unless a finished pair waits on the output.
	assign adv = !sc_valid || take;
	assign s_tready = adv && !took_q;
	assign in_acc = s_tvalid && s_tready;

	// Register each accepted beat so that accepted input beats are never back to back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took_q <= 1'b0;
		end else begin
			took_q <= in_acc;
		end
	end

	gps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_acc    (in_acc),
		.u_in      (s_tdata[U_W-1:0]),
		.v_in      (s_tdata[2*U_W-1:U_W]),
		.out_valid (lg_valid),
		.out_data  (lg_data)
	);

	gps_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (lg_valid),
		.in_data   (lg_data),
		.out_valid (rt_valid),
		.out_data  (rt_data)
	);

	gps_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (rt_valid),
		.in_data    (rt_data),
		.std_dev    (std_q),
		.mean_value (mean_q),
		.out_valid  (sc_valid),
		.out_data   (sc_data)
	);

	gps_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair_valid (sc_valid),
		.pair_in    (sc_data),
		.take       (take),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_sample   (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

FILE: tb/gps_checker.sv
// Checker for the polar Gaussian sampler: predicts each pair's samples and compares the stream.
`timescale 1ns / 1ps
module gps_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gps_pkg::CFG_A_W-1:0]      cfg_addr,
	input  logic [gps_pkg::SAMPLE_BITS-1:0]  cfg_data,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [2*gps_pkg::U_W-1:0]        s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [gps_pkg::SAMPLE_BITS-1:0]  m_tdata,
	input  logic                             m_tlast,
	output int                               errors,
	output int                               pending
);
	import gps_pkg::*;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   last;
	} gauss_beat_t;

	logic signed [SAMPLE_BITS-1:0] mean_reg;
	logic [STD_W-1:0]              std_reg;
	gauss_beat_t                   sample_queue[$];

	assign pending = sample_queue.size();

	// Integer square root, rounded down.
	function automatic longint unsigned isqrt(input longint unsigned val);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > val)
			bitv >>= 2;
		while (bitv != 0) begin
			if (val >= res + bitv) begin
				val -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Scale one uniform by the root factor and the deviation, add the mean and clamp.
	function automatic logic [SAMPLE_BITS-1:0] scale_sample(input logic signed [U_W-1:0] x,
			input longint unsigned root, input int h);
		longint unsigned mag, w, z, prod, m;
		longint total;
		mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
		w = mag * root;
		z = (h >= F_W) ? (w << (h - F_W)) : (w >> (F_W - h));
		prod = longint'(std_reg) * z;
		m = prod >> STD_SHIFT;
		total = longint'(mean_reg) + ((x < 0) ? -longint'(m) : longint'(m));
		if (total > (64'sd1 <<< (SAMPLE_BITS - 1)) - 1)
			total = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
		if (total < -(64'sd1 <<< (SAMPLE_BITS - 1)))
			total = -(64'sd1 <<< (SAMPLE_BITS - 1));
		return total[SAMPLE_BITS-1:0];
	endfunction

	// Work out the two samples of a pair; returns 0 when the pair is rejected.
	function automatic bit predict_pair(input logic [2*U_W-1:0] data,
			output logic [SAMPLE_BITS-1:0] first, output logic [SAMPLE_BITS-1:0] second);
		logic signed [U_W-1:0] u, v;
		longint unsigned um, vm, s, t, x, frac, lval, num, q, root;
		int top, k, h;
		u = data[U_W-1:0];
		v = data[2*U_W-1:U_W];
		um = (u < 0) ? longint'(-longint'(u)) : longint'(u);
		vm = (v < 0) ? longint'(-longint'(v)) : longint'(v);
		s = um * um + vm * vm;
		first = '0;
		second = '0;
		if (s == 0 || s >= (64'd1 << S_W))
			return 0;
		top = 0;
		for (int i = 0; i < 64; i++)
			if (s[i])
				top = i;
		t = (top >= LOGQ) ? (s >> (top - LOGQ)) : (s << (LOGQ - top));
		k = S_W - top;
		// Fraction bits of log2(t) by repeated squaring.
		frac = 0;
		x = t;
		for (int i = 0; i < LOGQ; i++) begin
			x = (x * x) >> LOGQ;
			if (x >= (64'd2 << LOGQ)) begin
				x >>= 1;
				frac |= 64'd1 << (LOGQ - 1 - i);
			end
		end
		lval = (longint'(k) << LOGQ) - frac;
		num = (lval * 64'd5814540) >> 22;
		if (k % 2 == 1) begin
			num <<= 1;
			h = (k - 1) / 2;
		end else begin
			h = k / 2;
		end
		q = (num << 26) / (t >> 6);
		root = isqrt(q);
		first = scale_sample(u, root, h);
		second = scale_sample(v, root, h);
		return 1;
	endfunction

	// Track register writes, predict accepted pairs and compare output beats.
	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_BITS-1:0] a, b;
		gauss_beat_t            want;
		if (!arst_n) begin
			mean_reg <= '0;
			std_reg  <= STD_RESET;
			errors   <= 0;
			sample_queue.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_MEAN)
					mean_reg <= cfg_data;
				else if (cfg_addr == REG_STD)
					std_reg <= cfg_data[STD_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				if (predict_pair(s_tdata, a, b)) begin
					sample_queue.push_back('{a, 1'b0});
					sample_queue.push_back('{b, 1'b1});
				end
			end
			if (m_tvalid && m_tready) begin
				if (sample_queue.size() == 0) begin
					$display("%0t: unexpected beat sample=%h last=%b", $time, m_tdata, m_tlast);
					errors <= errors + 1;
				end else begin
					want = sample_queue.pop_front();
					if (m_tdata !== want.sample || m_tlast !== want.last) begin
						$display("%0t: mismatch expected sample=%h last=%b, got sample=%h last=%b",
							$time, want.sample, want.last, m_tdata, m_tlast);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

FILE: tb/tb_top.sv
// Top of the polar Gaussian sampler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import gps_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_A_W-1:0]       cfg_addr = '0;
	logic [SAMPLE_BITS-1:0]   cfg_data = '0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [2*U_W-1:0]         s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [SAMPLE_BITS-1:0]   m_tdata;
	logic                     m_tlast;
	int                       errors;
	int                       pending;
	bit                       no_idle = 1'b0;
	bit                       long_hold = 1'b0;

	always #4 clk = ~clk;

	gaussian_polar_sampler dut (.*);

	gps_checker checker_i (.*);

	// Receiver: random stalls per beat, and one long hold-off on request.
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				long_hold = 1'b0;
			end
			wait_cycles = no_idle ? 0 : $urandom_range(0, 14);
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_tready <= 1'b1;
			while (!m_tvalid)
				@(negedge clk);
		end
	end

	// Offer one pair after a random gap and hold it until taken; called at a falling edge.
	// Ready is looked at shortly after the falling edge, once the receiver's tready has settled.
	task automatic send_pair(input logic signed [U_W-1:0] u, input logic signed [U_W-1:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, u};
		#1;
		while (!s_tready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	// Drain the pipeline, including rejected pairs still in flight, then write both registers.
	task automatic set_regs(input logic [SAMPLE_BITS-1:0] mean, input logic [STD_W-1:0] dev);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= REG_MEAN;
		cfg_data <= mean;
		@(negedge clk);
		cfg_addr <= REG_STD;
		cfg_data <= SAMPLE_BITS'(dev);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random pair: mostly full range, some small magnitudes, some near the unit circle.
	task automatic send_random();
		int sel;
		logic signed [U_W-1:0] u, v;
		sel = $urandom_range(0, 9);
		if (sel < 6) begin
			u = U_W'($urandom);
			v = U_W'($urandom);
		end else if (sel < 8) begin
			u = U_W'(int'($urandom_range(0, 511)) - 256);
			v = U_W'(int'($urandom_range(0, 511)) - 256);
		end else begin
			u = U_W'(int'($urandom_range(0, 46340)) - 23170);
			v = U_W'((($urandom_range(0, 1) == 1) ? 1 : -1) *
				int'($urandom_range(22000, 23200)));
		end
		send_pair(u, v);
	endtask

	// Stimulus: directed corners, then random phases under several register settings.
	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Corners of the fields and the rejection boundary, with reset registers.
		send_pair(16'sd0, 16'sd0);
		send_pair(-16'sd32768, 16'sd0);
		send_pair(16'sd0, -16'sd32768);
		send_pair(-16'sd32768, -16'sd32768);
		send_pair(16'sd32767, 16'sd0);
		send_pair(16'sd0, -16'sd32767);
		send_pair(16'sd1, 16'sd0);
		send_pair(16'sd0, -16'sd1);
		send_pair(-16'sd1, 16'sd1);
		send_pair(16'sd23170, 16'sd23170);
		send_pair(16'sd23170, -16'sd23171);
		send_pair(-16'sd32767, 16'sd1);
		send_pair(16'sd32767, 16'sd32767);
		send_pair(16'sd16384, -16'sd16384);
		send_pair(16'sd3, 16'sd4);

		// Saturation up and down, zero std, unit std with no gaps, then random settings.
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_regs(24'h7FFFFF, 16'hFFFF);
				1: set_regs(24'h800000, 16'hFFFF);
				2: set_regs(24'h000000, 16'h0000);
				3: set_regs(24'h000000, 16'h1000);
				default: set_regs(SAMPLE_BITS'($urandom), STD_W'($urandom));
			endcase
			no_idle = (phase == 3);
			if (phase == 1) begin
				// Directed repeats under the low-mean setting to hit negative clamping.
				send_pair(16'sd1, -16'sd1);
				send_pair(-16'sd32767, 16'sd0);
			end
			if (phase == 4)
				long_hold = 1'b1;
			for (int n = 0; n < 205; n++)
				send_random();
			// Let every expected sample come back before the next setting.
			s_tvalid <= 1'b0;
			while (pending != 0)
				@(negedge clk);
		end

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end
endmodule

FILE: sim.f
rtl/gps_pkg.sv
rtl/gps_front.sv
rtl/gps_divsqrt.sv
rtl/gps_scale.sv
rtl/gps_out.sv
rtl/gaussian_polar_sampler.sv
tb/gps_checker.sv
tb/tb_top.sv
